// File: rtl/core/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

  // Pattern positions, and so the depth of the byte window
  localparam int PATTERN_MAX = 16;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int WIN_IW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int COUNT_W     = 32;
  localparam int CFG_DW      = 64;
  localparam int CFG_IW      = 2;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PAT_LO   = 2'd0,
    CFG_PAT_HI   = 2'd1,
    CFG_CARE     = 2'd2,
    CFG_LENGTH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } out_item_t;

  typedef struct packed {
    logic [63:0] pattern_bytes_low;
    logic [63:0] pattern_bytes_high;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
  } cfg_t;

  // Verdict on one byte: emit a result, and whether it is a hit
  typedef struct packed {
    logic               emit;
    logic               hit;
    logic [COUNT_W-1:0] offset;
  } match_t;

endpackage

// File: rtl/core/wbps_cfg_regs.sv
`timescale 1ns / 1ps

module wbps_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wbps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DW-1:0] cfg_wdata,
  output wbps_pkg::cfg_t             cfg
);

  wbps_pkg::cfg_t cfg_r;
  wbps_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (wbps_pkg::cfg_reg_t'(cfg_index))
        wbps_pkg::CFG_PAT_LO: cfg_nxt.pattern_bytes_low  = cfg_wdata;
        wbps_pkg::CFG_PAT_HI: cfg_nxt.pattern_bytes_high = cfg_wdata;
        wbps_pkg::CFG_CARE:   cfg_nxt.care_mask          = cfg_wdata[15:0];
        wbps_pkg::CFG_LENGTH: cfg_nxt.pattern_length     = cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/wbps_match.sv
`timescale 1ns / 1ps

module wbps_match (
  input  wbps_pkg::cfg_t                       cfg,
  input  logic [7:0]                           win [wbps_pkg::PATTERN_MAX],
  input  logic [7:0]                           data_byte,
  input  logic                                 last_byte,
  input  logic [wbps_pkg::COUNT_W-1:0]         count,
  input  logic                                 reported,
  output wbps_pkg::match_t                     result
);

  logic [127:0]                     pat;
  logic [wbps_pkg::LEN_W-1:0]       len;
  logic [7:0]                       nw [wbps_pkg::PATTERN_MAX];
  logic [wbps_pkg::PATTERN_MAX-1:0] pos_ok;
  logic [wbps_pkg::COUNT_W-1:0]     have;
  logic [wbps_pkg::COUNT_W-1:0]     len_ext;
  logic                             hit;

  assign pat = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

  // Clamp the length to the window depth
  always_comb begin
    if (cfg.pattern_length > 5'(wbps_pkg::PATTERN_MAX)) begin
      len = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX);
    end else begin
      len = wbps_pkg::LEN_W'(cfg.pattern_length);
    end
  end

  // Window as it stands once this byte is shifted in
  always_comb begin
    nw[0] = data_byte;
    for (int i = 1; i < wbps_pkg::PATTERN_MAX; i++) begin
      nw[i] = win[i-1];
    end
  end

  always_comb begin
    logic [wbps_pkg::LEN_W-1:0] idx;
    for (int p = 0; p < wbps_pkg::PATTERN_MAX; p++) begin
      idx = len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(p);
      pos_ok[p] = (wbps_pkg::LEN_W'(p) >= len) || !cfg.care_mask[p] ||
                  (pat[8*p +: 8] == nw[idx[wbps_pkg::WIN_IW-1:0]]);
    end
  end

  assign have    = count + wbps_pkg::COUNT_W'(1);
  assign len_ext = {{(wbps_pkg::COUNT_W-wbps_pkg::LEN_W){1'b0}}, len};
  assign hit     = !reported &&
                   ((len == '0) || ((have >= len_ext) && (&pos_ok)));

  always_comb begin
    result.hit    = hit;
    result.emit   = hit || (last_byte && !reported);
    result.offset = '0;
    if (hit) begin
      result.offset = (len == '0) ? count : (have - len_ext);
    end
  end

endmodule

// File: rtl/core/wildcard_byte_pattern_search.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Payload
// in_      input      in_valid/in_stall   in_data  (data_byte, last_byte)
// out_     output     out_valid/out_stall out_data (found, match_offset)
// cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_stall does not hold a waiting result;
// a result is presented once its byte has passed the input register, then the
// result register.
// The window compare against all pattern positions is combinational.
// Reset (synchronous, rst_n low) clears configuration, window and count.
// out_stall holds a waiting result and, while the input register is full too,
// raises in_stall in the same cycle.

module wildcard_byte_pattern_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wbps_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wbps_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [wbps_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DW-1:0] cfg_wdata
);

  wbps_pkg::cfg_t   cfg;
  wbps_pkg::match_t mres;

  logic                         s1_valid_r, s1_valid_nxt;
  wbps_pkg::in_item_t           s1_data_r, s1_data_nxt;
  logic [7:0]                   win_r   [wbps_pkg::PATTERN_MAX];
  logic [7:0]                   win_nxt [wbps_pkg::PATTERN_MAX];
  logic [wbps_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                         reported_r, reported_nxt;
  logic                         out_valid_r, out_valid_nxt;
  wbps_pkg::out_item_t          out_data_r, out_data_nxt;
  logic                         out_free;
  logic                         s1_adv;
  logic                         in_xfer;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_match u_match (
    .cfg       (cfg),
    .win       (win_r),
    .data_byte (s1_data_r.data_byte),
    .last_byte (s1_data_r.last_byte),
    .count     (count_r),
    .reported  (reported_r),
    .result    (mres)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_data_nxt   = s1_data_r;
    win_nxt       = win_r;
    count_nxt     = count_r;
    reported_nxt  = reported_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_data;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (s1_adv) begin
      // advance the window and the per-buffer state
      win_nxt[0] = s1_data_r.data_byte;
      for (int i = 1; i < wbps_pkg::PATTERN_MAX; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      if (s1_data_r.last_byte) begin
        count_nxt    = '0;
        reported_nxt = 1'b0;
      end else begin
        count_nxt    = count_r + wbps_pkg::COUNT_W'(1);
        reported_nxt = reported_r || mres.hit;
      end
      out_valid_nxt             = mres.emit;
      out_data_nxt.found        = mres.hit;
      out_data_nxt.match_offset = mres.offset;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      reported_r  <= 1'b0;
      for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      reported_r  <= reported_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> (out_data_r.match_offset == '0))
    else $error("not-found result carries a nonzero offset");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.last_byte) |=> ((count_r == '0) && !reported_r))
    else $error("buffer end did not clear count and report flag");

  a_hit_sets_report: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && mres.hit && !s1_data_r.last_byte) |=> reported_r)
    else $error("report flag not set after a match");

  a_no_double_report: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> !mres.hit)
    else $error("second match reported within one buffer");

endmodule

// File: dv/wildcard_byte_pattern_search_test.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  wbps_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  wbps_pkg::out_item_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [wbps_pkg::CFG_IW-1:0]   cfg_index = '0;
  logic [wbps_pkg::CFG_DW-1:0]   cfg_wdata = '0;

  wildcard_byte_pattern_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Scanner state as the block should hold it
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [15:0] care_bits = '0;
  logic [4:0]  pat_len = '0;
  logic [7:0]  window [16] = '{default: 8'h00};
  logic [31:0] byte_count = '0;
  bit          reported = 1'b0;

  wbps_pkg::in_item_t  byte_queue [$];
  wbps_pkg::out_item_t expected_results [$];

  int queued_total = 0;
  int accepted_total = 0;
  int buffers_sent = 0;
  int settings_used = 0;
  int results_checked = 0;
  int hits = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int long_hold_request = 0;
  bit steady_phase = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("wildcard_byte_pattern_search verification failed");
      $finish;
    end
  end

  function automatic int active_len();
    int l;
    l = pat_len;
    return (l > wbps_pkg::PATTERN_MAX) ? wbps_pkg::PATTERN_MAX : l;
  endfunction

  function automatic logic [7:0] pattern_at(int p);
    return (p < 8) ? pat_lo[8*p +: 8] : pat_hi[8*(p-8) +: 8];
  endfunction

  function automatic bit window_matches(int len);
    for (int p = 0; p < len; p++)
      if (care_bits[p] && pattern_at(p) != window[len-1-p]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the window by one byte and queue the verdict it produces, if any
  function automatic void scan_byte(wbps_pkg::in_item_t item);
    int len;
    logic [31:0] seen;
    logic [31:0] have;
    wbps_pkg::out_item_t res;
    bit emit;
    len = active_len();
    seen = byte_count;
    have = seen + 32'd1;
    for (int i = 15; i > 0; i--) window[i] = window[i-1];
    window[0] = item.data_byte;
    res = '0;
    emit = 1'b0;
    if (!reported) begin
      if (len == 0) begin
        emit = 1'b1;
        res.found = 1'b1;
        res.match_offset = seen;
      end else if (have >= 32'(len) && window_matches(len)) begin
        emit = 1'b1;
        res.found = 1'b1;
        res.match_offset = have - 32'(len);
      end else if (item.last_byte) begin
        emit = 1'b1;
      end
      if (res.found) reported = 1'b1;
    end
    if (emit) expected_results.push_back(res);
    if (item.last_byte) begin
      byte_count = '0;
      reported = 1'b0;
    end else begin
      byte_count = have;
    end
  endfunction

  function automatic void check_result(wbps_pkg::out_item_t got);
    wbps_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: found %0d match_offset %0d",
             got.found, got.match_offset);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (want.found) hits++;
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      errors++;
    end
    if (got.match_offset !== want.match_offset) begin
      $error("match_offset: expected %0d, got %0d",
             want.match_offset, got.match_offset);
      errors++;
    end
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one; none in a steady phase
  function automatic int idle_span();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data);
        accepted_total++;
        send_gap = idle_span();
      end
      // a stalled transfer keeps its byte
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (byte_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (long_hold_request > 0) begin
        stall_left = long_hold_request;
        long_hold_request = 0;
      end else if (stall_left == 0) begin
        stall_left = idle_span();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    wbps_pkg::in_item_t item;
    item.data_byte = b;
    item.last_byte = last;
    byte_queue.push_back(item);
    queued_total++;
    if (last) buffers_sent++;
  endtask

  task automatic put_reg(wbps_pkg::cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      wbps_pkg::CFG_PAT_LO: pat_lo = val;
      wbps_pkg::CFG_PAT_HI: pat_hi = val;
      wbps_pkg::CFG_CARE:   care_bits = val[15:0];
      wbps_pkg::CFG_LENGTH: pat_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic write_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] care,
                              logic [63:0] len);
    put_reg(wbps_pkg::CFG_PAT_LO, lo);
    put_reg(wbps_pkg::CFG_PAT_HI, hi);
    put_reg(wbps_pkg::CFG_CARE, care);
    put_reg(wbps_pkg::CFG_LENGTH, len);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Hold until every byte is transferred and every result is back, then let
  // the pipeline empty of bytes that produce no result
  task automatic wait_idle();
    while (accepted_total != queued_total || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    // '?', ' ', '0', 'A'
    logic [7:0] marks [4] = '{8'h3F, 8'h20, 8'h30, 8'h41};
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] care;
    logic [63:0] len_reg;
    logic [7:0] b;
    int target;
    int phase;
    int n_buf;
    int n;
    int len_eff;
    int start;
    int mode;
    int r;
    bit terminate;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern: every buffer matches at offset zero on its first byte
    write_config('0, '0, '0, '0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b1);
    wait_idle();

    // Length above the maximum clips to 16; match flush against the buffer end
    write_config(64'h7F80_00FF_3F20_3041, 64'h0102_0408_1020_40A5, 64'hFFFF, 64'd31);
    for (int p = 0; p < 16; p++) push_byte(pattern_at(p), p == 15);
    wait_idle();

    // "A?C" with a wildcard in the middle; later bytes after a report stay quiet
    write_config(64'h0000_0000_0043_3F41, '0, 64'h0005, 64'd3);
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(8'h41, 1'b1);
    // pattern longer than the buffer never matches
    push_byte(8'h41, 1'b1);
    // leave a buffer open across a reconfiguration
    push_byte(8'h41, 1'b0);
    push_byte(8'h20, 1'b0);
    wait_idle();
    write_config(64'h0000_0000_0000_0043, '0, 64'h0001, 64'd1);
    push_byte(8'h43, 1'b1);
    wait_idle();

    target = queued_total + RANDOM_BYTES;
    phase = 0;
    while (queued_total < target) begin
      steady_phase = (phase == 2) || ($urandom_range(0, 3) == 0);
      lo = '0;
      hi = '0;
      for (int p = 0; p < 16; p++) begin
        b = ($urandom_range(0, 9) < 3) ? marks[$urandom_range(0, 3)]
                                       : 8'($urandom_range(0, 255));
        if (p < 8) lo[8*p +: 8] = b;
        else hi[8*(p-8) +: 8] = b;
      end
      r = $urandom_range(0, 99);
      care = {$urandom(), $urandom()};
      if (r < 15) care[15:0] = 16'hFFFF;
      else if (r < 25) care[15:0] = 16'h0000;
      len_reg = {$urandom(), $urandom()};
      r = $urandom_range(0, 99);
      if (r < 8) len_reg[4:0] = 5'd0;
      else if (r < 22) len_reg[4:0] = 5'd16;
      else if (r < 30) len_reg[4:0] = 5'($urandom_range(17, 31));
      else len_reg[4:0] = 5'($urandom_range(1, 8));
      write_config(lo, hi, care, len_reg);
      len_eff = active_len();

      // fill the block while the receiver holds off
      if (phase == 2) long_hold_request = 150;
      n_buf = $urandom_range(4, 12);
      for (int k = 0; k < n_buf; k++) begin
        if (phase == 4 && k == n_buf / 2) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 70) n = $urandom_range(1, len_eff + 6);
        else if (r < 95) n = $urandom_range(1, 40);
        else n = $urandom_range(60, 160);
        terminate = !(k == n_buf - 1 && $urandom_range(0, 2) == 0);
        // plant the pattern somewhere, against the end, nearly, or not at all
        mode = $urandom_range(0, 9);
        start = (len_eff <= n) ? $urandom_range(0, n - len_eff) : 0;
        if (mode >= 6 && len_eff <= n) start = n - len_eff;
        for (int i = 0; i < n; i++) begin
          if (len_eff > 0 && $urandom_range(0, 3) == 0)
            b = pattern_at($urandom_range(0, len_eff - 1));
          else
            b = 8'($urandom_range(0, 255));
          if (mode < 8 && len_eff > 0 && i >= start && i < start + len_eff) begin
            if (care_bits[i - start]) b = pattern_at(i - start);
            if (mode == 0 && i == start + len_eff - 1) b = b ^ (8'h01 << $urandom_range(0, 7));
          end
          push_byte(b, terminate && i == n - 1);
        end
      end
      wait_idle();
      phase++;
    end

    repeat (6) @(posedge clk);
    $display("Scanned %0d bytes in %0d buffers over %0d pattern settings",
             accepted_total, buffers_sent, settings_used);
    $display("Checked %0d verdicts, %0d of them matches", results_checked, hits);
    if (errors == 0) begin
      $display("wildcard_byte_pattern_search verification clean");
    end else begin
      $display("wildcard_byte_pattern_search verification failed");
    end
    $finish;
  end

endmodule
